### hdl/range_assign_range_max_tree_macros.svh
// Assertion macros shared by the range maximum tree.
`ifndef RANGE_ASSIGN_RANGE_MAX_TREE_MACROS_SVH
`define RANGE_ASSIGN_RANGE_MAX_TREE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define RARMT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("range max tree check failed");
// Next-cycle implication, checked outside reset.
`define RARMT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("range max tree check failed");
`else
`define RARMT_ASSERT_NOW(label, ante, cons)
`define RARMT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### hdl/rarmt_pkg.sv
`default_nettype none
package rarmt_pkg;

  localparam int VAL_W      = 64;
  localparam int POS_W      = 11;
  localparam int LEAVES_DEF = 1024;

  localparam logic signed [VAL_W-1:0] MOST_NEG = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic [4:0] {
    OP_NONE, OP_CLEAR, OP_LOAD, OP_PUSH_RD, OP_HOLD, OP_WR_CH0, OP_WR_CH1,
    OP_WR_SELF, OP_LVL_DN, OP_WALK_INIT, OP_WALK_L, OP_WALK_R, OP_ACC,
    OP_WALK_UP, OP_UPD_INIT, OP_UPD_RD0, OP_UPD_RD1, OP_UPD_WR, OP_LVL_UP, OP_OUT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic side;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic in_empty;
    logic query;
    logic cond_l;
    logic cond_r;
    logic walk_more;
    logic lo_odd;
    logic hi_odd;
    logic tag;
    logic lvl_one;
    logic lvl_top;
    logic out_busy;
  } sts_t;

  function automatic logic signed [VAL_W-1:0] smax(input logic signed [VAL_W-1:0] a,
                                                   input logic signed [VAL_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

endpackage
`default_nettype wire

### hdl/range_assign_range_max_tree.sv
// Channel   Direction  Handshake            Beat contents
// in        into block in_valid / in_stall   action, range_start, range_end, value
// out       out of blk out_valid / out_stall max_value (one beat per query)
//
// After reset a clearing pass writes every tree node, during which in_stall is held high.
// A non-empty item passes through a downward tag push and a level walk, and an assign
// then an upward refresh, over L = ceil(log2(LEAVES)) levels; the single tree memory,
// one read and one write per cycle, paces these phases.
// One item is worked at a time; a finished result waits in the output register, so the
// next beat is taken while out_stall holds the previous result.
`default_nettype none
`include "range_assign_range_max_tree_macros.svh"
module range_assign_range_max_tree #(
  parameter int LEAVES = rarmt_pkg::LEAVES_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic                               action,
  input  wire logic [rarmt_pkg::POS_W-1:0]        range_start,
  input  wire logic [rarmt_pkg::POS_W-1:0]        range_end,
  input  wire logic signed [rarmt_pkg::VAL_W-1:0] value,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [rarmt_pkg::VAL_W-1:0]      max_value
);
  import rarmt_pkg::*;

  // The controller sequences push, walk and refresh phases; the datapath owns the
  // tree memory, in which each node keeps its maximum together with a pending-tag
  // bit. A pending tag always equals the node's own maximum, so no second store
  // is needed for the tag value.
  cmd_t cmd;
  sts_t sts;

  rarmt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .sts(sts), .cmd(cmd)
  );

  rarmt_dp #(.LEAVES(LEAVES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .action(action),
    .range_start(range_start), .range_end(range_end), .value(value),
    .out_valid(out_valid), .out_stall(out_stall), .max_value(max_value)
  );

  // A taken beat always keeps the block busy in the following cycle.
  `RARMT_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall)
  // A new result appears only at the end of work on an item.
  `RARMT_ASSERT_NOW(a_result_from_work, $rose(out_valid), $past(in_stall))
  // The clearing pass holds off input straight after reset.
  `RARMT_ASSERT_NOW(a_clear_blocks, $past(rst), in_stall)

endmodule
`default_nettype wire

### hdl/rarmt_ram.sv
`default_nettype none
module rarmt_ram #(
  parameter int WIDTH = 65,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### hdl/rarmt_dp.sv
`default_nettype none
module rarmt_dp #(
  parameter int LEAVES = rarmt_pkg::LEAVES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire rarmt_pkg::cmd_t                cmd,
  output rarmt_pkg::sts_t                     sts,
  input  wire logic                           action,
  input  wire logic [rarmt_pkg::POS_W-1:0]    range_start,
  input  wire logic [rarmt_pkg::POS_W-1:0]    range_end,
  input  wire logic signed [rarmt_pkg::VAL_W-1:0] value,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic signed [rarmt_pkg::VAL_W-1:0]  max_value
);
  import rarmt_pkg::*;

  localparam int LOG   = $clog2(LEAVES);
  localparam int N     = 1 << LOG;
  localparam int DEPTH = 2 * N;
  localparam int AW    = LOG + 1;
  localparam int PW    = LOG + 2;
  localparam int LW    = $clog2(LOG + 2);

  logic [PW-1:0] lo, hi, l0, r0;
  logic [LW-1:0] lvl;
  logic [AW-1:0] k, clr;
  logic signed [VAL_W-1:0] acc, vreg;
  logic query;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [VAL_W:0] wdata, rd;
  logic signed [VAL_W-1:0] rd_val;
  logic [31:0]   a_c, b_c;
  logic [PW-1:0] nl, nr, rm1;
  logic [AW-1:0] sn;

  rarmt_ram #(.WIDTH(VAL_W + 1), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd)
  );

  assign rd_val = rd[VAL_W-1:0];
  assign rm1    = r0 - PW'(1);
  assign nl     = l0 >> lvl;
  assign nr     = rm1 >> lvl;
  assign sn     = cmd.side ? nr[AW-1:0] : nl[AW-1:0];

  always_comb begin
    a_c = ({21'b0, range_start} > 32'(LEAVES)) ? 32'(LEAVES) : {21'b0, range_start};
    b_c = ({21'b0, range_end} > 32'(LEAVES)) ? 32'(LEAVES) : {21'b0, range_end};
  end

  always_comb begin
    sts.clr_done  = (clr == AW'(DEPTH - 1));
    sts.in_empty  = (a_c >= b_c);
    sts.query     = query;
    sts.cond_l    = ((nl << lvl) != l0);
    sts.cond_r    = ((r0 >> lvl) << lvl) != r0;
    sts.walk_more = (lo < hi);
    sts.lo_odd    = lo[0];
    sts.hi_odd    = hi[0];
    sts.tag       = rd[VAL_W];
    sts.lvl_one   = (lvl == LW'(1));
    sts.lvl_top   = (lvl == LW'(LOG));
    sts.out_busy  = out_valid && out_stall;
  end

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = '0;
    case (cmd.op)
      OP_CLEAR: begin
        we = 1'b1; waddr = clr; wdata = {1'b0, MOST_NEG};
      end
      OP_PUSH_RD: raddr = sn;
      OP_WR_CH0: begin
        we = 1'b1; waddr = {k[AW-2:0], 1'b0}; wdata = {~sts.lvl_one, acc};
      end
      OP_WR_CH1: begin
        we = 1'b1; waddr = {k[AW-2:0], 1'b1}; wdata = {~sts.lvl_one, acc};
      end
      OP_WR_SELF: begin
        we = 1'b1; waddr = k; wdata = {1'b0, acc};
      end
      OP_WALK_L: begin
        raddr = lo[AW-1:0];
        we = ~query; waddr = lo[AW-1:0]; wdata = {(lvl != '0), vreg};
      end
      OP_WALK_R: begin
        raddr = (hi[AW-1:0] - AW'(1));
        we = ~query; waddr = (hi[AW-1:0] - AW'(1)); wdata = {(lvl != '0), vreg};
      end
      OP_UPD_RD0: raddr = {sn[AW-2:0], 1'b0};
      OP_UPD_RD1: raddr = {k[AW-2:0], 1'b1};
      OP_UPD_WR: begin
        we = 1'b1; waddr = k; wdata = {1'b0, smax(acc, rd_val)};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        lo    <= PW'(a_c + 32'(N));
        l0    <= PW'(a_c + 32'(N));
        hi    <= PW'(b_c + 32'(N));
        r0    <= PW'(b_c + 32'(N));
        query <= action;
        vreg  <= value;
        acc   <= MOST_NEG;
        lvl   <= LW'(LOG);
      end
      OP_PUSH_RD:   k   <= sn;
      OP_HOLD:      acc <= rd_val;
      OP_LVL_DN:    lvl <= lvl - LW'(1);
      OP_WALK_INIT: begin
        lvl <= '0;
        acc <= MOST_NEG;
      end
      OP_WALK_L:    lo  <= lo + PW'(1);
      OP_WALK_R:    hi  <= hi - PW'(1);
      OP_ACC:       acc <= smax(acc, rd_val);
      OP_WALK_UP: begin
        lo  <= lo >> 1;
        hi  <= hi >> 1;
        lvl <= lvl + LW'(1);
      end
      OP_UPD_INIT:  lvl <= LW'(1);
      OP_UPD_RD0:   k   <= sn;
      OP_UPD_RD1:   acc <= rd_val;
      OP_LVL_UP:    lvl <= lvl + LW'(1);
      OP_OUT:       max_value <= acc;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == OP_CLEAR) begin
        clr <= clr + AW'(1);
      end
      if (cmd.op == OP_OUT) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

### hdl/rarmt_ctrl.sv
`default_nettype none
module rarmt_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire rarmt_pkg::sts_t sts,
  output rarmt_pkg::cmd_t      cmd
);
  import rarmt_pkg::*;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_P_RD, S_P_CHK, S_P_W1, S_P_W2, S_P_W3, S_P_ADV, S_W_INIT,
    S_W_L, S_W_LA, S_W_R, S_W_RA, S_W_UP, S_U_INIT, S_U_RD0, S_U_RD1, S_U_WR,
    S_U_ADV, S_FIN
  } state_t;

  state_t state, state_next;
  logic   side, side_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    side_next  = side;
    cmd.op     = OP_NONE;
    cmd.side   = side;
    unique case (state)
      S_CLR: begin
        cmd.op = OP_CLEAR;
        if (sts.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          side_next = 1'b0;
          state_next = sts.in_empty ? S_FIN : S_P_RD;
        end
      end
      S_P_RD: begin
        if (side ? sts.cond_r : sts.cond_l) begin
          cmd.op = OP_PUSH_RD;
          state_next = S_P_CHK;
        end else begin
          state_next = S_P_ADV;
        end
      end
      S_P_CHK: begin
        cmd.op = OP_HOLD;
        state_next = sts.tag ? S_P_W1 : S_P_ADV;
      end
      S_P_W1: begin
        cmd.op = OP_WR_CH0;
        state_next = S_P_W2;
      end
      S_P_W2: begin
        cmd.op = OP_WR_CH1;
        state_next = S_P_W3;
      end
      S_P_W3: begin
        cmd.op = OP_WR_SELF;
        state_next = S_P_ADV;
      end
      S_P_ADV: begin
        if (!side) begin
          side_next = 1'b1;
          state_next = S_P_RD;
        end else begin
          side_next = 1'b0;
          if (sts.lvl_one) begin
            state_next = S_W_INIT;
          end else begin
            cmd.op = OP_LVL_DN;
            state_next = S_P_RD;
          end
        end
      end
      S_W_INIT: begin
        cmd.op = OP_WALK_INIT;
        state_next = S_W_L;
      end
      S_W_L: begin
        if (!sts.walk_more) begin
          state_next = sts.query ? S_FIN : S_U_INIT;
        end else if (sts.lo_odd) begin
          cmd.op = OP_WALK_L;
          state_next = sts.query ? S_W_LA : S_W_R;
        end else begin
          state_next = S_W_R;
        end
      end
      S_W_LA: begin
        cmd.op = OP_ACC;
        state_next = S_W_R;
      end
      S_W_R: begin
        if (sts.hi_odd) begin
          cmd.op = OP_WALK_R;
          state_next = sts.query ? S_W_RA : S_W_UP;
        end else begin
          state_next = S_W_UP;
        end
      end
      S_W_RA: begin
        cmd.op = OP_ACC;
        state_next = S_W_UP;
      end
      S_W_UP: begin
        cmd.op = OP_WALK_UP;
        state_next = S_W_L;
      end
      S_U_INIT: begin
        cmd.op = OP_UPD_INIT;
        side_next = 1'b0;
        state_next = S_U_RD0;
      end
      S_U_RD0: begin
        if (side ? sts.cond_r : sts.cond_l) begin
          cmd.op = OP_UPD_RD0;
          state_next = S_U_RD1;
        end else begin
          state_next = S_U_ADV;
        end
      end
      S_U_RD1: begin
        cmd.op = OP_UPD_RD1;
        state_next = S_U_WR;
      end
      S_U_WR: begin
        cmd.op = OP_UPD_WR;
        state_next = S_U_ADV;
      end
      S_U_ADV: begin
        if (!side) begin
          side_next = 1'b1;
          state_next = S_U_RD0;
        end else begin
          side_next = 1'b0;
          if (sts.lvl_top) begin
            state_next = S_FIN;
          end else begin
            cmd.op = OP_LVL_UP;
            state_next = S_U_RD0;
          end
        end
      end
      S_FIN: begin
        if (!sts.query) begin
          state_next = S_IDLE;
        end else if (!sts.out_busy) begin
          cmd.op = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      side  <= 1'b0;
    end else begin
      state <= state_next;
      side  <= side_next;
    end
  end

endmodule
`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none

// Checks the range-assign / range-maximum tree against a simple array model.
// The model keeps one signed 64-bit word per element: an assign writes the
// clamped range and a query scans it, which gives the same answers as the lazy
// tree inside the block without copying its structure.

// Holds the element array and the queue of maxima that queries still owe.
class max_scoreboard;
  logic signed [63:0] elem [1024];
  logic signed [63:0] owed_max [$];
  int errors;

  function void clear();
    for (int i = 0; i < 1024; i++) elem[i] = rarmt_pkg::MOST_NEG;
    owed_max.delete();
    errors = 0;
  endfunction

  // Applies one accepted beat: an assign writes the array, a query queues its maximum.
  function void note_beat(logic act, logic [10:0] s, logic [10:0] e,
                          logic signed [63:0] v);
    int a;
    int b;
    logic signed [63:0] m;
    a = (s > 1024) ? 1024 : s;
    b = (e > 1024) ? 1024 : e;
    if (act == 1'b0) begin
      for (int i = a; i < b; i++) elem[i] = v;
    end else begin
      m = rarmt_pkg::MOST_NEG;
      for (int i = a; i < b; i++) if (elem[i] > m) m = elem[i];
      owed_max.push_back(m);
    end
  endfunction

  // Returns 0 on a match, 1 on an unexpected beat, 2 on a wrong value.
  function int check_result(logic signed [63:0] got, output logic signed [63:0] want);
    want = '0;
    if (owed_max.size() == 0) return 1;
    want = owed_max.pop_front();
    return (got === want) ? 0 : 2;
  endfunction
endclass

module tb_top;
  localparam logic ACT_ASSIGN = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;
  localparam int   RANDOM_BEATS = 1900;
  localparam int   IDLE_LIMIT = 20000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic action;
  logic [10:0] range_start;
  logic [10:0] range_end;
  logic signed [63:0] value;
  logic out_valid;
  logic out_stall;
  logic signed [63:0] max_value;

  max_scoreboard sb;
  bit stimulus_done;
  int idle_cycles;
  int fail_count;

  range_assign_range_max_tree uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .range_start(range_start), .range_end(range_end), .value(value),
    .out_valid(out_valid), .out_stall(out_stall), .max_value(max_value)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Every mismatch passes through here so that it is printed once and counted.
  task automatic report(input string what);
    fail_count++;
    $display("tb_top: mismatch at %0t: %s", $realtime, what);
  endtask

  // Offers one beat after the given gap and holds it until in_stall reads low after an edge.
  // The gap is drawn per beat, so idle cycles land on every phase of a walk.
  // With no gap the next beat follows straight on, so valid stays high.
  task automatic send_beat(input logic act, input logic [10:0] s, input logic [10:0] e,
                           input logic signed [63:0] v, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    action      <= act;
    range_start <= s;
    range_end   <= e;
    value       <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_beat(act, s, e, v);
  endtask

  function automatic logic signed [63:0] rand_value();
    case ($urandom_range(0, 5))
      0: return rarmt_pkg::MOST_NEG;
      1: return 64'sh7fff_ffff_ffff_ffff;
      2: return $signed(64'($urandom_range(0, 20)) - 64'd10);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Mostly sensible ranges inside the tree, with some beyond the end and
  // some empty or reversed, so the clamping and empty cases keep turning up.
  function automatic logic [10:0] rand_pos();
    case ($urandom_range(0, 9))
      0: return 11'($urandom_range(1025, 2047));
      1: return 11'd1024;
      2: return 11'd0;
      default: return 11'($urandom_range(0, 1024));
    endcase
  endfunction

  // Input side: directed beats first, then the random run.
  initial begin
    logic [10:0] s;
    logic [10:0] e;
    sb = new();
    sb.clear();
    fail_count = 0;
    stimulus_done = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    action = ACT_ASSIGN;
    range_start = '0;
    range_end = '0;
    value = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // The tree is fresh: every element reads as the most negative value.
    send_beat(ACT_QUERY, 11'd0, 11'd1024, '0, 0);
    send_beat(ACT_ASSIGN, 11'd0, 11'd1024, 64'sh7fff_ffff_ffff_ffff, 0);
    send_beat(ACT_QUERY, 11'd0, 11'd1024, '0, 0);
    // Assigning the most negative value must still overwrite the elements.
    send_beat(ACT_ASSIGN, 11'd0, 11'd512, rarmt_pkg::MOST_NEG, 1);
    send_beat(ACT_QUERY, 11'd0, 11'd512, '0, 0);
    send_beat(ACT_QUERY, 11'd511, 11'd513, '0, 0);
    // Bounds beyond the tree saturate; the all-ones patterns exercise every bit.
    send_beat(ACT_ASSIGN, 11'd1023, 11'd2047, 64'sd5, 0);
    send_beat(ACT_QUERY, 11'd1023, 11'd2047, 64'sh7fff_ffff_ffff_ffff, 0);
    send_beat(ACT_QUERY, 11'd2047, 11'd2047, '1, 0);
    // Empty and reversed ranges: an assign changes nothing.
    send_beat(ACT_ASSIGN, 11'd700, 11'd300, 64'sd99, 0);
    send_beat(ACT_ASSIGN, 11'd300, 11'd300, 64'sd99, 0);
    send_beat(ACT_QUERY, 11'd300, 11'd300, '0, 0);
    send_beat(ACT_QUERY, 11'd700, 11'd300, '0, 0);
    send_beat(ACT_QUERY, 11'd0, 11'd1024, '0, 2);
    send_beat(ACT_ASSIGN, 11'd0, 11'd1, -64'sd1, 0);
    send_beat(ACT_QUERY, 11'd0, 11'd1, '0, 0);
    send_beat(ACT_QUERY, 11'd1, 11'd1024, '0, 0);

    // Random run: about half the beats are queries; a stretch with no gaps
    // in the middle keeps the block fully loaded for a while.
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      s = rand_pos();
      e = rand_pos();
      if ($urandom_range(0, 3) != 0 && s > e) begin
        logic [10:0] t;
        t = s; s = e; e = t;
      end
      send_beat(logic'($urandom_range(0, 1)), s, e, rand_value(),
                (n > 600 && n < 800) ? 0 : $urandom_range(0, 7));
    end
    in_valid <= 1'b0;
    stimulus_done = 1'b1;
  end

  // Output side: random stalls per result, a long hold-off early in the
  // random run so that a result waits and the input backs up behind it, and
  // also some stall-free stretches.
  initial begin
    int hold;
    int taken;
    out_stall = 1'b0;
    taken = 0;
    @(negedge rst);
    forever begin
      if ($urandom_range(0, 3) == 0) hold = 0;
      else hold = $urandom_range(0, 7);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
      if (taken == 100) begin
        out_stall <= 1'b1;
        repeat (1500) @(posedge clk);
      end
    end
  end

  // Checks every accepted result beat against the oldest owed maximum.
  always @(posedge clk) begin
    logic signed [63:0] want;
    int verdict;
    if (!rst && out_valid && !out_stall) begin
      verdict = sb.check_result(max_value, want);
      if (verdict == 1) report($sformatf("unexpected result %0d", max_value));
      else if (verdict == 2)
        report($sformatf("max_value %0d, expected %0d", max_value, want));
    end
  end

  // Watchdog: counts cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  // End of run: all beats in, all maxima back, then a short settling time.
  initial begin
    @(negedge rst);
    while (!(stimulus_done && sb.owed_max.size() == 0)) @(posedge clk);
    repeat (500) @(posedge clk);
    if (fail_count == 0 && sb.owed_max.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end
endmodule

`default_nettype wire

### files.f
+incdir+hdl
hdl/rarmt_pkg.sv
hdl/rarmt_ram.sv
hdl/rarmt_dp.sv
hdl/rarmt_ctrl.sv
hdl/range_assign_range_max_tree.sv
sim/tb_top.sv
